### rtl/zbsf_pkg.sv
// Shared widths, codes and types of the z-buffered span fill block.
package zbsf_pkg;

  // Field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 9;
  localparam int unsigned Z_W     = 32;
  localparam int unsigned COLOR_W = 24;

  // Bresenham error term; holds values within about +/- 2 * 512
  localparam int unsigned ERR_W = 12;

  localparam logic [Z_W-1:0] FAR_DEPTH = '1;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_SPAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DOTS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // Divider result: quotient and remainder, valid on the done pulse and held after
  typedef struct packed {
    logic             done;
    logic [Z_W-1:0]   quotient;
    logic [COL_W-1:0] remainder;
  } div_res_t;

endpackage

### rtl/zbuffer_span_fill.sv
// Depth-buffered span fill: sequencer, stepper and frame memories.
//
// Usage: drive the in_ fields and raise start while busy is low; that cycle
// accepts the transaction. busy then stays high until the result strobe.
// Every transaction returns exactly one result, one cycle long on out_valid
// with out_pixel_color / out_pixel_depth (zero except for a pixel read).
// The receiver cannot stall; the result is simply presented for one cycle.
// Work from accept to strobe:
//   read pixel       one memory read
//   end dots         two read-compare-write passes on the memory
//   span fill        one divider pass first when the depth change
//                    exceeds the column count (one quotient bit per
//                    cycle); pixels then stream one per cycle through a
//                    read, compare, write pipeline
//   clear row        one pixel write per cycle
//   empty span, off-frame read, span or clear row out of range: none
// After reset the block sweeps both memories to far depth and black, one
// pixel per cycle, with busy held high meanwhile.
module zbuffer_span_fill #(
  parameter int unsigned WIDTH  = 256,
  parameter int unsigned HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [zbsf_pkg::MODE_W-1:0]   in_mode,
  input  logic [zbsf_pkg::ROW_W-1:0]    in_row,
  input  logic [zbsf_pkg::COL_W-1:0]    in_start_col,
  input  logic [zbsf_pkg::COL_W-1:0]    in_end_col,
  input  logic [zbsf_pkg::Z_W-1:0]      in_z_start,
  input  logic [zbsf_pkg::Z_W-1:0]      in_z_end,
  input  logic [zbsf_pkg::COLOR_W-1:0]  in_color,
  output logic                          out_valid,
  output logic [zbsf_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic [zbsf_pkg::Z_W-1:0]      out_pixel_depth
);

  localparam int unsigned NPIX = WIDTH * HEIGHT;
  localparam int unsigned AW   = $clog2(NPIX);
  localparam logic [AW-1:0] LAST_PIX = AW'(NPIX - 1);
  localparam logic [AW-1:0] LAST_COL = AW'(WIDTH - 1);

  localparam int unsigned ZW = zbsf_pkg::Z_W;
  localparam int unsigned CW = zbsf_pkg::COL_W;
  localparam int unsigned EW = zbsf_pkg::ERR_W;
  localparam int unsigned KW = zbsf_pkg::COLOR_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHK, S_DIV, S_SETUP, S_SPAN,
    S_DOT0, S_DOT1, S_DOT2, S_RD, S_RDW, S_CLEAR, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Transaction fields
  logic [zbsf_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                        row_ok_r, row_ok_nxt;
  logic [CW-1:0]               sc_r, sc_nxt;
  logic [CW-1:0]               ec_r, ec_nxt;
  logic [ZW-1:0]               zs_r, zs_nxt;
  logic [ZW-1:0]               ze_r, ze_nxt;
  logic [KW-1:0]               color_r, color_nxt;
  logic [AW-1:0]               base_r, base_nxt;

  // Stepper setup
  logic [ZW-1:0]               dz_r, dz_nxt;
  logic                        neg_r, neg_nxt;
  logic [CW-1:0]               dh_r, dh_nxt;
  logic                        divided_r, divided_nxt;

  // Stepper state
  logic [CW-1:0]               col_r, col_nxt;
  logic [ZW-1:0]               z_r, z_nxt;
  logic [ZW-1:0]               inc_lo_r, inc_lo_nxt;
  logic [ZW-1:0]               inc_hi_r, inc_hi_nxt;
  logic [EW-1:0]               err_r, err_nxt;
  logic [EW-1:0]               err_a_r, err_a_nxt;
  logic [EW-1:0]               err_b_r, err_b_nxt;
  logic [AW-1:0]               sweep_r, sweep_nxt;

  // Compare stage
  logic                        p_valid_r, p_valid_nxt;
  logic                        p_ok_r, p_ok_nxt;
  logic [ZW-1:0]               p_z_r, p_z_nxt;
  logic [AW-1:0]               p_addr_r, p_addr_nxt;
  logic [KW-1:0]               p_color_r, p_color_nxt;

  // Result registers
  logic                        out_valid_r, out_valid_nxt;
  logic [KW-1:0]               out_color_r, out_color_nxt;
  logic [ZW-1:0]               out_depth_r, out_depth_nxt;

  // Memory ports
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [ZW-1:0]               rd_depth, wr_depth;
  logic [KW-1:0]               rd_color, wr_color;

  // Divider
  logic                        div_start;
  zbsf_pkg::div_res_t          div_res;

  // Misc combinational
  logic                        accept;
  logic                        iss_en;
  logic [CW-1:0]               iss_col;
  logic [ZW-1:0]               iss_z;
  logic [AW-1:0]               iss_addr;
  logic                        err_ge;
  logic [ZW-1:0]               q_sel;
  logic [CW-1:0]               r_sel;
  logic [EW-1:0]               dz2;
  logic [EW-1:0]               dh1;
  logic                        cmp_wr;

  assign accept = start && (state_r == S_IDLE);
  assign err_ge = !err_r[EW-1];
  assign iss_addr = base_r + AW'(iss_col);

  // Quotient and remainder feeding the setup step
  assign q_sel = divided_r ? div_res.quotient : '0;
  assign r_sel = divided_r ? div_res.remainder : dz_r[CW-1:0];
  assign dz2   = EW'({r_sel, 1'b0});
  assign dh1   = EW'(dh_r);

  // Compare stage: write where the new depth is nearer
  assign cmp_wr = p_valid_r && p_ok_r && (p_z_r < rd_depth);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    row_ok_nxt    = row_ok_r;
    sc_nxt        = sc_r;
    ec_nxt        = ec_r;
    zs_nxt        = zs_r;
    ze_nxt        = ze_r;
    color_nxt     = color_r;
    base_nxt      = base_r;
    dz_nxt        = dz_r;
    neg_nxt       = neg_r;
    dh_nxt        = dh_r;
    divided_nxt   = divided_r;
    col_nxt       = col_r;
    z_nxt         = z_r;
    inc_lo_nxt    = inc_lo_r;
    inc_hi_nxt    = inc_hi_r;
    err_nxt       = err_r;
    err_a_nxt     = err_a_r;
    err_b_nxt     = err_b_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = 1'b0;
    out_color_nxt = out_color_r;
    out_depth_nxt = out_depth_r;
    div_start     = 1'b0;
    iss_en        = 1'b0;
    iss_col       = col_r;
    iss_z         = z_r;
    rd_en         = 1'b0;
    rd_addr       = iss_addr;

    unique case (state_r)
      S_INIT: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_PIX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_mode;
          row_ok_nxt = 32'(in_row) < HEIGHT;
          sc_nxt     = in_start_col;
          ec_nxt     = in_end_col;
          zs_nxt     = in_z_start;
          ze_nxt     = in_z_end;
          color_nxt  = in_color;
          base_nxt   = AW'(32'(in_row) * 32'(WIDTH));
          neg_nxt    = in_z_end < in_z_start;
          dz_nxt     = (in_z_end < in_z_start) ? (in_z_start - in_z_end)
                                               : (in_z_end - in_z_start);
          dh_nxt     = in_end_col - in_start_col;
          sweep_nxt  = '0;
          unique case (in_mode)
            zbsf_pkg::MODE_SPAN: begin
              if ((in_end_col > in_start_col) && (32'(in_row) < HEIGHT)) begin
                state_nxt = S_CHK;
              end else begin
                state_nxt = S_DONE;
              end
            end
            zbsf_pkg::MODE_DOTS: state_nxt = S_DOT0;
            zbsf_pkg::MODE_READ: begin
              if ((32'(in_row) < HEIGHT) && (32'(in_start_col) < WIDTH)) begin
                state_nxt = S_RD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            zbsf_pkg::MODE_CLEAR: begin
              state_nxt = (32'(in_row) < HEIGHT) ? S_CLEAR : S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Whole-step part only when depth changes faster than one per column
      S_CHK: begin
        if (dz_r > ZW'(dh_r)) begin
          div_start   = 1'b1;
          divided_nxt = 1'b1;
          state_nxt   = S_DIV;
        end else begin
          divided_nxt = 1'b0;
          state_nxt   = S_SETUP;
        end
      end

      S_DIV: begin
        if (div_res.done) begin
          state_nxt = S_SETUP;
        end
      end

      // Signed increments and error terms
      S_SETUP: begin
        inc_lo_nxt = neg_r ? (~q_sel + 1'b1) : q_sel;
        if (dz_r == '0) begin
          inc_hi_nxt = '0;
        end else begin
          inc_hi_nxt = neg_r ? ~q_sel : (q_sel + 1'b1);
        end
        err_nxt   = dz2 - dh1;
        err_a_nxt = dz2;
        err_b_nxt = dz2 - {dh1[EW-2:0], 1'b0};
        col_nxt   = sc_r;
        z_nxt     = zs_r;
        state_nxt = S_SPAN;
      end

      // One column issued per cycle; the compare stage works on the registered issue
      S_SPAN: begin
        if (col_r < ec_r) begin
          iss_en  = 1'b1;
          rd_en   = 1'b1;
          col_nxt = col_r + 1'b1;
          z_nxt   = z_r + (err_ge ? inc_hi_r : inc_lo_r);
          err_nxt = err_r + (err_ge ? err_b_r : err_a_r);
        end else begin
          state_nxt = S_DONE;
        end
      end

      // First dot, then a gap so a shared pixel sees the first write
      S_DOT0: begin
        iss_en    = 1'b1;
        iss_col   = sc_r;
        iss_z     = zs_r;
        rd_en     = 1'b1;
        state_nxt = S_DOT1;
      end

      S_DOT1: begin
        state_nxt = S_DOT2;
      end

      S_DOT2: begin
        iss_en    = 1'b1;
        iss_col   = ec_r;
        iss_z     = ze_r;
        rd_en     = 1'b1;
        state_nxt = S_DONE;
      end

      S_RD: begin
        iss_col   = sc_r;
        rd_en     = 1'b1;
        state_nxt = S_RDW;
      end

      S_RDW: begin
        out_valid_nxt = 1'b1;
        out_color_nxt = rd_color;
        out_depth_nxt = rd_depth;
        state_nxt     = S_IDLE;
      end

      S_CLEAR: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_COL) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_color_nxt = '0;
        out_depth_nxt = '0;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Compare stage load
  always_comb begin
    p_valid_nxt = iss_en;
    p_ok_nxt    = row_ok_r && (32'(iss_col) < WIDTH);
    p_z_nxt     = iss_z;
    p_addr_nxt  = iss_addr;
    p_color_nxt = (mode_r == zbsf_pkg::MODE_SPAN) ? color_r : '0;
  end

  // Write port: reset sweep, row clear, or depth-tested pixel
  always_comb begin
    if (state_r == S_INIT) begin
      wr_en    = 1'b1;
      wr_addr  = sweep_r;
      wr_depth = zbsf_pkg::FAR_DEPTH;
      wr_color = '0;
    end else if (state_r == S_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = base_r + sweep_r;
      wr_depth = zbsf_pkg::FAR_DEPTH;
      wr_color = color_r;
    end else begin
      wr_en    = cmp_wr;
      wr_addr  = p_addr_r;
      wr_depth = p_z_r;
      wr_color = p_color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r      <= mode_nxt;
    row_ok_r    <= row_ok_nxt;
    sc_r        <= sc_nxt;
    ec_r        <= ec_nxt;
    zs_r        <= zs_nxt;
    ze_r        <= ze_nxt;
    color_r     <= color_nxt;
    base_r      <= base_nxt;
    dz_r        <= dz_nxt;
    neg_r       <= neg_nxt;
    dh_r        <= dh_nxt;
    divided_r   <= divided_nxt;
    col_r       <= col_nxt;
    z_r         <= z_nxt;
    inc_lo_r    <= inc_lo_nxt;
    inc_hi_r    <= inc_hi_nxt;
    err_r       <= err_nxt;
    err_a_r     <= err_a_nxt;
    err_b_r     <= err_b_nxt;
    p_ok_r      <= p_ok_nxt;
    p_z_r       <= p_z_nxt;
    p_addr_r    <= p_addr_nxt;
    p_color_r   <= p_color_nxt;
    out_color_r <= out_color_nxt;
    out_depth_r <= out_depth_nxt;
  end

  zbsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dz_r),
    .divisor  (dh_r),
    .res      (div_res)
  );

  zbsf_ram #(
    .DW    (ZW),
    .DEPTH (NPIX)
  ) u_depth_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_depth),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_depth)
  );

  zbsf_ram #(
    .DW    (KW),
    .DEPTH (NPIX)
  ) u_color_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_color),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_color)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_pixel_depth = out_depth_r;

  // The strobe only appears once the block is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  // Results other than a pixel read carry zeros
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (mode_r != zbsf_pkg::MODE_READ))
      |-> (out_color_r == '0) && (out_depth_r == '0))
    else $error("nonzero result for a non-read transaction");

  // Nothing is written to the frame while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("memory write while idle");

  // The compare stage never competes with the sweep writes
  a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_INIT) || (state_r == S_CLEAR)) |-> !p_valid_r)
    else $error("pixel compare during a sweep");

  // A strobe follows an accept only through the state register, then the strobe register
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid_r ##1 1'b1)
    else $error("result strobe right after accept");

endmodule

### rtl/zbsf_ram.sv
// Generic simple dual-port RAM with registered read.
module zbsf_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/zbsf_div.sv
// Restoring divider, one quotient bit per cycle: depth span over column count.
module zbsf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [zbsf_pkg::Z_W-1:0]    dividend,
  input  logic [zbsf_pkg::COL_W-1:0]  divisor,
  output zbsf_pkg::div_res_t          res
);

  localparam int unsigned CNT_W = $clog2(zbsf_pkg::Z_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(zbsf_pkg::Z_W - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [zbsf_pkg::Z_W-1:0]     quo_r, quo_nxt;
  logic [zbsf_pkg::COL_W-1:0]   rem_r, rem_nxt;
  logic [zbsf_pkg::COL_W-1:0]   dsr_r, dsr_nxt;
  logic [zbsf_pkg::COL_W:0]     trial;
  logic                         fits;

  // Shift in the next dividend bit and try to subtract the divisor
  assign trial = {rem_r, quo_r[zbsf_pkg::Z_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[zbsf_pkg::Z_W-2:0], fits};
      rem_nxt = fits ? zbsf_pkg::COL_W'(trial - {1'b0, dsr_r})
                     : trial[zbsf_pkg::COL_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

### test/zbsf_checker.sv
`timescale 1ns / 1ps
// Frame predictor and result scoreboard for the z-buffered span fill block.
module zbsf_checker #(
  parameter int unsigned WIDTH  = 256,
  parameter int unsigned HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [zbsf_pkg::MODE_W-1:0]   in_mode,
  input  logic [zbsf_pkg::ROW_W-1:0]    in_row,
  input  logic [zbsf_pkg::COL_W-1:0]    in_start_col,
  input  logic [zbsf_pkg::COL_W-1:0]    in_end_col,
  input  logic [zbsf_pkg::Z_W-1:0]      in_z_start,
  input  logic [zbsf_pkg::Z_W-1:0]      in_z_end,
  input  logic [zbsf_pkg::COLOR_W-1:0]  in_color,
  input  logic                          out_valid,
  input  logic [zbsf_pkg::COLOR_W-1:0]  out_pixel_color,
  input  logic [zbsf_pkg::Z_W-1:0]      out_pixel_depth,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding,
  output int unsigned                   results_checked,
  output int unsigned                   depth_updates,
  output int unsigned                   span_count,
  output int unsigned                   dots_count,
  output int unsigned                   read_count,
  output int unsigned                   clear_count
);
  import zbsf_pkg::*;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [Z_W-1:0]     depth;
  } readback_t;

  // Predicted frame contents
  logic [Z_W-1:0]     depth_map [WIDTH*HEIGHT];
  logic [COLOR_W-1:0] color_map [WIDTH*HEIGHT];

  // Readbacks owed by the block, oldest first
  readback_t readback_q[$];

  // Depth-tested pixel write; off-frame pixels are dropped
  function automatic void depth_test_write(int unsigned row, int unsigned col,
                                           logic [Z_W-1:0] z, logic [COLOR_W-1:0] c);
    int unsigned idx;
    if (row >= HEIGHT || col >= WIDTH) return;
    idx = row * WIDTH + col;
    if (z < depth_map[idx]) begin
      depth_map[idx] = z;
      color_map[idx] = c;
      depth_updates++;
    end
  endfunction

  // Span walk: whole step from one divide, remainder spread Bresenham style
  function automatic void fill_span(int unsigned row, int unsigned sc, int unsigned ec,
                                    logic [Z_W-1:0] z0, logic [Z_W-1:0] z1,
                                    logic [COLOR_W-1:0] c);
    longint run, dz, dir, whole, err, run2, dz2, z, za, zb;
    int unsigned col;
    if (ec <= sc || row >= HEIGHT) return;
    za = {32'd0, z0};
    zb = {32'd0, z1};
    run = longint'(ec) - longint'(sc);
    dz = zb - za;
    dir = 0;
    if (dz > 0) begin
      dir = 1;
    end else if (dz < 0) begin
      dz = -dz;
      dir = -1;
    end
    whole = 0;
    if (dz > run) begin
      whole = dz / run;
      dz = dz - whole * run;
      whole = whole * dir;
    end
    dz2 = dz * 2;
    err = dz2 - run;
    run2 = run * 2;
    z = za;
    for (col = sc; col < ec; col++) begin
      depth_test_write(row, col, z[Z_W-1:0], c);
      z = z + whole;
      if (err >= 0) begin
        z = z + dir;
        err = err - run2;
      end
      err = err + dz2;
    end
  endfunction

  // Apply one command to the predicted frame and return the readback it owes
  function automatic readback_t apply_command(logic [MODE_W-1:0] mode, int unsigned row,
                                              int unsigned sc, int unsigned ec,
                                              logic [Z_W-1:0] zs, logic [Z_W-1:0] ze,
                                              logic [COLOR_W-1:0] c);
    readback_t rb;
    int unsigned k;
    rb.color = '0;
    rb.depth = '0;
    case (mode)
      MODE_SPAN: begin
        span_count++;
        fill_span(row, sc, ec, zs, ze, c);
      end
      MODE_DOTS: begin
        dots_count++;
        depth_test_write(row, sc, zs, '0);
        depth_test_write(row, ec, ze, '0);
      end
      MODE_READ: begin
        read_count++;
        if (row < HEIGHT && sc < WIDTH) begin
          rb.color = color_map[row * WIDTH + sc];
          rb.depth = depth_map[row * WIDTH + sc];
        end
      end
      MODE_CLEAR: begin
        clear_count++;
        if (row < HEIGHT) begin
          for (k = 0; k < WIDTH; k++) begin
            depth_map[row * WIDTH + k] = FAR_DEPTH;
            color_map[row * WIDTH + k] = c;
          end
        end
      end
      default: ;
    endcase
    return rb;
  endfunction

  // Compare each result first, then take in the transaction accepted at this edge
  always @(posedge clk) begin : monitor
    readback_t want;
    int unsigned k;
    if (!rst_n) begin
      for (k = 0; k < WIDTH * HEIGHT; k++) begin
        depth_map[k] = FAR_DEPTH;
        color_map[k] = '0;
      end
      readback_q.delete();
      mismatches = 0;
      results_checked = 0;
      depth_updates = 0;
      span_count = 0;
      dots_count = 0;
      read_count = 0;
      clear_count = 0;
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (readback_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got color %h depth %h",
                   $time, out_pixel_color, out_pixel_depth);
        end else begin
          want = readback_q.pop_front();
          results_checked++;
          if (out_pixel_color !== want.color) begin
            mismatches++;
            $display("%0t: pixel_color mismatch: expected %h, got %h",
                     $time, want.color, out_pixel_color);
          end
          if (out_pixel_depth !== want.depth) begin
            mismatches++;
            $display("%0t: pixel_depth mismatch: expected %h, got %h",
                     $time, want.depth, out_pixel_depth);
          end
        end
      end
      if (start && !busy) begin
        readback_q.push_back(apply_command(in_mode, in_row, in_start_col, in_end_col,
                                           in_z_start, in_z_end, in_color));
      end
      outstanding <= readback_q.size();
    end
  end

endmodule

### test/tb_zbuffer_span_fill.sv
`timescale 1ns / 1ps
// Testbench top for zbuffer_span_fill: stimulus, watchdog and verdict.
module tb_zbuffer_span_fill;
  import zbsf_pkg::*;

  localparam int unsigned WIDTH        = 256;
  localparam int unsigned HEIGHT       = 256;
  localparam int unsigned RANDOM_ITEMS = 600;
  // Covers the post-reset memory sweep several times over
  localparam int unsigned STALL_LIMIT  = 4 * WIDTH * HEIGHT;
  localparam int unsigned DRAIN_CYCLES = 2 * WIDTH;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   in_mode = '0;
  logic [ROW_W-1:0]    in_row = '0;
  logic [COL_W-1:0]    in_start_col = '0;
  logic [COL_W-1:0]    in_end_col = '0;
  logic [Z_W-1:0]      in_z_start = '0;
  logic [Z_W-1:0]      in_z_end = '0;
  logic [COLOR_W-1:0]  in_color = '0;
  logic                out_valid;
  logic [COLOR_W-1:0]  out_pixel_color;
  logic [Z_W-1:0]      out_pixel_depth;

  int unsigned mismatches, outstanding, results_checked, depth_updates;
  int unsigned span_count, dots_count, read_count, clear_count;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_cycles = 0;

  zbuffer_span_fill #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_start_col    (in_start_col),
    .in_end_col      (in_end_col),
    .in_z_start      (in_z_start),
    .in_z_end        (in_z_end),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .out_pixel_depth (out_pixel_depth)
  );

  zbsf_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_start_col    (in_start_col),
    .in_end_col      (in_end_col),
    .in_z_start      (in_z_start),
    .in_z_end        (in_z_end),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .out_pixel_depth (out_pixel_depth),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .depth_updates   (depth_updates),
    .span_count      (span_count),
    .dots_count      (dots_count),
    .read_count      (read_count),
    .clear_count     (clear_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles with neither a transaction nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Optional sender gap with junk on the fields, then hold start until accepted
  task automatic issue(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                       input logic [COL_W-1:0] sc, input logic [COL_W-1:0] ec,
                       input logic [Z_W-1:0] zs, input logic [Z_W-1:0] ze,
                       input logic [COLOR_W-1:0] color);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start        <= 1'b0;
      in_mode      <= MODE_W'($urandom_range(0, 3));
      in_row       <= ROW_W'($urandom());
      in_start_col <= COL_W'($urandom());
      in_end_col   <= COL_W'($urandom());
      in_z_start   <= $urandom();
      in_z_end     <= $urandom();
      in_color     <= COLOR_W'($urandom());
      @(posedge clk);
    end
    start        <= 1'b1;
    in_mode      <= mode;
    in_row       <= row;
    in_start_col <= sc;
    in_end_col   <= ec;
    in_z_start   <= zs;
    in_z_end     <= ze;
    in_color     <= color;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Rows cluster on a few lines so reads find drawn pixels
  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(0, 4))
      0: return ROW_W'(0);
      1: return ROW_W'(85);
      2: return ROW_W'(170);
      3: return ROW_W'(HEIGHT - 1);
      default: return ROW_W'($urandom_range(0, HEIGHT - 1));
    endcase
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    case ($urandom_range(0, 9))
      0: return COL_W'(0);
      1: return COL_W'(WIDTH);
      2: return COL_W'(WIDTH - 1);
      default: return COL_W'($urandom_range(0, WIDTH));
    endcase
  endfunction

  function automatic logic [Z_W-1:0] pick_depth();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FAR_DEPTH;
      2: return Z_W'($urandom_range(0, 4096));
      3: return FAR_DEPTH - Z_W'($urandom_range(0, 4096));
      default: return $urandom();
    endcase
  endfunction

  task automatic random_command();
    logic [MODE_W-1:0]  mode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   sc, ec;
    logic [Z_W-1:0]     zs, ze;
    int unsigned        pick, len;
    pick = $urandom_range(0, 99);
    row = pick_row();
    sc = pick_col();
    ec = pick_col();
    zs = pick_depth();
    ze = pick_depth();
    if (pick < 40) begin
      mode = MODE_SPAN;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(1, 24);
          sc = COL_W'($urandom_range(0, WIDTH - 1));
          ec = (sc + len > WIDTH) ? COL_W'(WIDTH) : COL_W'(sc + len);
        end
        6: begin
          sc = '0;
          ec = COL_W'(WIDTH);
        end
        7: ec = COL_W'($urandom_range(0, sc));   // empty or reversed
        default: ;
      endcase
      // Flat slopes take the no-divide path, shallow ones often do
      case ($urandom_range(0, 3))
        0: ze = zs;
        1: ze = zs + Z_W'($urandom_range(0, 64)) - Z_W'(32);
        default: ;
      endcase
    end else if (pick < 55) begin
      mode = MODE_DOTS;
      if ($urandom_range(0, 4) == 0) ec = sc;
    end else if (pick < 88) begin
      mode = MODE_READ;
    end else begin
      mode = MODE_CLEAR;
    end
    issue(mode, row, sc, ec, zs, ze, COLOR_W'($urandom()));
  endtask

  initial begin : stimulus
    int unsigned item;
    sender_idle_pct = 23;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, extremes and the corner cases
    issue(MODE_READ,  8'd0,   9'd0,   9'd0,   '0,           '0,           '0);
    issue(MODE_READ,  8'd255, 9'd255, 9'd0,   '0,           '0,           '0);
    issue(MODE_SPAN,  8'd0,   9'd0,   9'd256, 32'h0,        32'hFFFF_FFFF, 24'hFF_FFFF);
    issue(MODE_READ,  8'd0,   9'd0,   9'd0,   '0,           '0,           '0);
    issue(MODE_READ,  8'd0,   9'd255, 9'd0,   '0,           '0,           '0);
    issue(MODE_CLEAR, 8'd0,   9'd0,   9'd0,   '0,           '0,           24'hA5_A5A5);
    issue(MODE_READ,  8'd0,   9'd100, 9'd0,   '0,           '0,           '0);
    issue(MODE_SPAN,  8'd0,   9'd10,  9'd10,  32'd1,        32'd2,        24'h11_2233);
    issue(MODE_SPAN,  8'd0,   9'd20,  9'd5,   32'd1,        32'd2,        24'h11_2233);
    issue(MODE_READ,  8'd0,   9'd10,  9'd0,   '0,           '0,           '0);
    issue(MODE_SPAN,  8'd1,   9'd250, 9'd256, 32'hFFFF_FFFF, 32'h0,       24'h12_3456);
    issue(MODE_READ,  8'd1,   9'd255, 9'd0,   '0,           '0,           '0);
    issue(MODE_SPAN,  8'd1,   9'd0,   9'd8,   32'd100,      32'd103,      24'h5A_5A5A);
    issue(MODE_READ,  8'd1,   9'd4,   9'd0,   '0,           '0,           '0);
    // Equal depth must not overwrite
    issue(MODE_SPAN,  8'd1,   9'd0,   9'd8,   32'd100,      32'd100,      24'h00_FF00);
    issue(MODE_DOTS,  8'd2,   9'd3,   9'd256, 32'd5,        32'd0,        '0);
    issue(MODE_DOTS,  8'd2,   9'd7,   9'd7,   32'd9,        32'd8,        '0);
    issue(MODE_READ,  8'd2,   9'd3,   9'd0,   '0,           '0,           '0);
    issue(MODE_READ,  8'd2,   9'd7,   9'd0,   '0,           '0,           '0);
    issue(MODE_READ,  8'd2,   9'd256, 9'd0,   '0,           '0,           '0);
    issue(MODE_DOTS,  8'd2,   9'd256, 9'd256, 32'd0,        32'd0,        '0);
    issue(MODE_CLEAR, 8'd255, 9'd0,   9'd0,   '0,           '0,           24'hFF_FFFF);
    issue(MODE_READ,  8'd255, 9'd0,   9'd0,   '0,           '0,           '0);
    issue(MODE_SPAN,  8'd255, 9'd0,   9'd1,   32'd0,        32'd0,        24'h00_0000);
    issue(MODE_READ,  8'd255, 9'd0,   9'd0,   '0,           '0,           '0);

    // Random: light sender gaps, heavy gaps, then back to back
    for (item = 0; item < RANDOM_ITEMS; item++) begin
      if (item == RANDOM_ITEMS / 3) sender_idle_pct = 81;
      else if (item == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      random_command();
    end
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d spans, %0d dot pairs, %0d reads, %0d row clears",
             span_count + dots_count + read_count + clear_count,
             span_count, dots_count, read_count, clear_count);
    $display("%0d results compared, %0d depth-test pixel writes predicted, %0d mismatches",
             results_checked, depth_updates, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
